// ===== design/lrrca_pkg.sv =====
// ----------------------------------------------------------------------------
// lrrca_pkg: shared types and constants for the channel allocator
// Field widths, command codes, controller states and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lrrca_pkg;

  localparam int NUM_PORTS_DEF    = 5;
  localparam int NUM_CHANNELS_DEF = 4;

  localparam int CMD_W  = 2;
  localparam int PORT_W = 3;
  localparam int CH_W   = 2;
  localparam int PEND_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_PICK    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOAD   = 2'd1,
    ST_SEARCH = 2'd2,
    ST_COMMIT = 2'd3
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_search;
    logic hit;
  } ctrl_sts_t;

endpackage

// ===== design/locking_round_robin_channel_allocator.sv =====
// ----------------------------------------------------------------------------
// locking_round_robin_channel_allocator: top level
// One transfer is taken while busy is low and start is high. It steps
// through capture, row load, search (only for a pick on an unlocked row,
// 1 to NUM_PORTS*NUM_CHANNELS round-robin positions) and write-back; the
// search cursor steps one request bit per cycle. The result appears on
// the out_ ports for exactly one cycle, marked by out_strobe, in the cycle
// after write-back; the receiver cannot stall it, so it must sample every
// strobe. A new start is taken in the same cycle that the strobe shows.
// ----------------------------------------------------------------------------
module locking_round_robin_channel_allocator #(
  parameter int NUM_PORTS    = lrrca_pkg::NUM_PORTS_DEF,
  parameter int NUM_CHANNELS = lrrca_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lrrca_pkg::CMD_W-1:0]   in_command,
  input  logic [lrrca_pkg::PORT_W-1:0]  in_out_port,
  input  logic [lrrca_pkg::CH_W-1:0]    in_out_ch,
  input  logic [lrrca_pkg::PORT_W-1:0]  in_in_port,
  input  logic [lrrca_pkg::CH_W-1:0]    in_in_ch,
  output logic                          out_strobe,
  output logic                          out_winner_valid,
  output logic [lrrca_pkg::PORT_W-1:0]  out_winner_port,
  output logic [lrrca_pkg::CH_W-1:0]    out_winner_ch,
  output logic                          out_was_requested,
  output logic [lrrca_pkg::PEND_W-1:0]  out_row_pending,
  output logic                          out_any_pending
);

  lrrca_pkg::ctrl_cmd_t cmd;
  lrrca_pkg::ctrl_sts_t sts;

  lrrca_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lrrca_dp #(
    .NUM_PORTS    (NUM_PORTS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_command        (in_command),
    .in_out_port       (in_out_port),
    .in_out_ch         (in_out_ch),
    .in_in_port        (in_in_port),
    .in_in_ch          (in_in_ch),
    .out_strobe        (out_strobe),
    .out_winner_valid  (out_winner_valid),
    .out_winner_port   (out_winner_port),
    .out_winner_ch     (out_winner_ch),
    .out_was_requested (out_was_requested),
    .out_row_pending   (out_row_pending),
    .out_any_pending   (out_any_pending)
  );

endmodule

// ===== design/lrrca_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrrca_ctrl: allocator sequencer
// Steps one transfer through capture, row load, round-robin search and
// write-back, and raises busy while an item is in flight.
// ----------------------------------------------------------------------------
module lrrca_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lrrca_pkg::ctrl_sts_t  sts,
  output lrrca_pkg::ctrl_cmd_t  cmd
);

  lrrca_pkg::state_t state_r;
  lrrca_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrrca_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      lrrca_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = lrrca_pkg::ST_LOAD;
        end
      end
      lrrca_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = sts.need_search ? lrrca_pkg::ST_SEARCH : lrrca_pkg::ST_COMMIT;
      end
      lrrca_pkg::ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.hit) begin
          state_nxt = lrrca_pkg::ST_COMMIT;
        end
      end
      lrrca_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = lrrca_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lrrca_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != lrrca_pkg::ST_IDLE);

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.load, cmd.step, cmd.commit}))
    else $error("controller issued more than one command");

endmodule

// ===== design/lrrca_dp.sv =====
// ----------------------------------------------------------------------------
// lrrca_dp: allocator datapath
// Per-row request bits, lock/done/known flags, round-robin pointers and
// pending counts; a stepping cursor for the round-robin search; result
// registers with a one-cycle strobe.
// ----------------------------------------------------------------------------
module lrrca_dp #(
  parameter int NUM_PORTS    = lrrca_pkg::NUM_PORTS_DEF,
  parameter int NUM_CHANNELS = lrrca_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lrrca_pkg::ctrl_cmd_t          cmd,
  output lrrca_pkg::ctrl_sts_t          sts,
  input  logic [lrrca_pkg::CMD_W-1:0]   in_command,
  input  logic [lrrca_pkg::PORT_W-1:0]  in_out_port,
  input  logic [lrrca_pkg::CH_W-1:0]    in_out_ch,
  input  logic [lrrca_pkg::PORT_W-1:0]  in_in_port,
  input  logic [lrrca_pkg::CH_W-1:0]    in_in_ch,
  output logic                          out_strobe,
  output logic                          out_winner_valid,
  output logic [lrrca_pkg::PORT_W-1:0]  out_winner_port,
  output logic [lrrca_pkg::CH_W-1:0]    out_winner_ch,
  output logic                          out_was_requested,
  output logic [lrrca_pkg::PEND_W-1:0]  out_row_pending,
  output logic                          out_any_pending
);

  localparam int NROWS = NUM_PORTS * NUM_CHANNELS;
  localparam int ROW_W = $clog2(NROWS);
  localparam int PW    = $clog2(NUM_PORTS);
  localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NROWS + 1);
  localparam int TOT_W = $clog2(NROWS * NROWS + 1);
  localparam int OPW   = lrrca_pkg::PORT_W;
  localparam int OCW   = lrrca_pkg::CH_W;
  localparam int OPDW  = lrrca_pkg::PEND_W;

  // captured item
  lrrca_pkg::cmd_t             cmd_r;
  logic [OPW-1:0]              op_r;
  logic [OCW-1:0]              oc_r;
  logic [OPW-1:0]              ip_r;
  logic [OCW-1:0]              ic_r;

  // row store
  logic [NROWS-1:0]            req_rows_r [NROWS];
  logic [CNT_W-1:0]            cnt_r      [NROWS];
  logic [ROW_W-1:0]            ptr_idx_r  [NROWS];
  logic [PW-1:0]               ptr_port_r [NROWS];
  logic [CW-1:0]               ptr_ch_r   [NROWS];
  logic [NROWS-1:0]            lock_r;
  logic [NROWS-1:0]            done_r;
  logic [NROWS-1:0]            known_r;
  logic [TOT_W-1:0]            total_r;

  // working copy of the addressed row
  logic [NROWS-1:0]            bits_w_r;
  logic [CNT_W-1:0]            cnt_w_r;
  logic                        lock_w_r;
  logic                        done_w_r;
  logic                        known_w_r;
  logic                        was_r;
  logic                        hit_r;
  logic [ROW_W-1:0]            cur_idx_r;
  logic [PW-1:0]               cur_port_r;
  logic [CW-1:0]               cur_ch_r;

  logic                        out_strobe_r;
  logic                        out_wv_r;
  logic [OPW-1:0]              out_wp_r;
  logic [OCW-1:0]              out_wc_r;
  logic                        out_was_r;
  logic [OPDW-1:0]             out_pend_r;
  logic                        out_any_r;

  logic                        row_ok;
  logic                        bit_ok;
  logic [ROW_W-1:0]            row_idx;
  logic [ROW_W-1:0]            bit_idx;
  logic [NROWS-1:0]            mask;
  logic [ROW_W-1:0]            adv_idx;
  logic [PW-1:0]               adv_port;
  logic [CW-1:0]               adv_ch;

  logic [NROWS-1:0]            bits_nxt;
  logic [CNT_W-1:0]            cnt_nxt;
  logic                        lock_nxt;
  logic                        done_nxt;
  logic                        known_nxt;
  logic [TOT_W-1:0]            total_nxt;
  logic                        wv_nxt;

  assign row_ok  = (32'(op_r) < NUM_PORTS) && (32'(oc_r) < NUM_CHANNELS);
  assign bit_ok  = (32'(ip_r) < NUM_PORTS) && (32'(ic_r) < NUM_CHANNELS);
  assign row_idx = row_ok ? ROW_W'(32'(op_r) * NUM_CHANNELS + 32'(oc_r)) : '0;
  assign bit_idx = bit_ok ? ROW_W'(32'(ip_r) * NUM_CHANNELS + 32'(ic_r)) : '0;
  assign mask    = bit_ok ? (NROWS'(1) << bit_idx) : '0;

  // advance the round-robin cursor by one position
  always_comb begin
    adv_idx  = (cur_idx_r == ROW_W'(NROWS - 1)) ? '0 : cur_idx_r + 1'b1;
    adv_port = cur_port_r;
    adv_ch   = cur_ch_r + 1'b1;
    if (cur_ch_r == CW'(NUM_CHANNELS - 1)) begin
      adv_ch   = '0;
      adv_port = (cur_port_r == PW'(NUM_PORTS - 1)) ? '0 : cur_port_r + 1'b1;
    end
  end

  assign sts.need_search = row_ok && (cmd_r == lrrca_pkg::CMD_PICK) &&
                           !done_r[row_idx] && !lock_r[row_idx] &&
                           (cnt_r[row_idx] != '0);
  assign sts.hit         = bits_w_r[adv_idx];

  // write-back values for the addressed row
  always_comb begin
    bits_nxt  = bits_w_r;
    cnt_nxt   = cnt_w_r;
    lock_nxt  = lock_w_r;
    done_nxt  = done_w_r;
    known_nxt = known_w_r;
    total_nxt = total_r;
    case (cmd_r)
      lrrca_pkg::CMD_REQUEST: begin
        if (bit_ok) begin
          bits_nxt = bits_w_r | mask;
          done_nxt = 1'b0;
          if (!was_r) begin
            cnt_nxt   = cnt_w_r + 1'b1;
            total_nxt = total_r + 1'b1;
          end
        end
      end
      lrrca_pkg::CMD_PICK: begin
        if (!done_w_r) begin
          if (lock_w_r) begin
            done_nxt = 1'b1;
          end else if (hit_r) begin
            known_nxt = 1'b1;
            lock_nxt  = 1'b1;
            done_nxt  = 1'b1;
          end
        end
      end
      lrrca_pkg::CMD_CLEAR: begin
        if (bit_ok) begin
          bits_nxt = bits_w_r & ~mask;
          lock_nxt = 1'b0;
          done_nxt = 1'b0;
          if (was_r) begin
            cnt_nxt   = cnt_w_r - 1'b1;
            total_nxt = total_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (!row_ok) begin
      total_nxt = total_r;
    end
  end

  assign wv_nxt = row_ok && lock_nxt && known_nxt;

  // capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= lrrca_pkg::cmd_t'(in_command);
      op_r  <= in_out_port;
      oc_r  <= in_out_ch;
      ip_r  <= in_in_port;
      ic_r  <= in_in_ch;
    end
  end

  // load the addressed row, then step the cursor during search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bits_w_r   <= req_rows_r[row_idx];
      cnt_w_r    <= cnt_r[row_idx];
      lock_w_r   <= lock_r[row_idx];
      done_w_r   <= done_r[row_idx];
      known_w_r  <= known_r[row_idx];
      cur_idx_r  <= ptr_idx_r[row_idx];
      cur_port_r <= ptr_port_r[row_idx];
      cur_ch_r   <= ptr_ch_r[row_idx];
      was_r      <= row_ok && bit_ok && req_rows_r[row_idx][bit_idx];
      hit_r      <= 1'b0;
    end else if (cmd.step) begin
      cur_idx_r  <= adv_idx;
      cur_port_r <= adv_port;
      cur_ch_r   <= adv_ch;
      if (bits_w_r[adv_idx]) begin
        hit_r <= 1'b1;
      end
    end
  end

  // row store write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NROWS; i++) begin
        req_rows_r[i] <= '0;
        cnt_r[i]      <= '0;
        ptr_idx_r[i]  <= '0;
        ptr_port_r[i] <= '0;
        ptr_ch_r[i]   <= '0;
      end
      lock_r  <= '0;
      done_r  <= '0;
      known_r <= '0;
      total_r <= '0;
    end else if (cmd.commit) begin
      total_r <= total_nxt;
      if (row_ok) begin
        req_rows_r[row_idx] <= bits_nxt;
        cnt_r[row_idx]      <= cnt_nxt;
        ptr_idx_r[row_idx]  <= cur_idx_r;
        ptr_port_r[row_idx] <= cur_port_r;
        ptr_ch_r[row_idx]   <= cur_ch_r;
        lock_r[row_idx]     <= lock_nxt;
        done_r[row_idx]     <= done_nxt;
        known_r[row_idx]    <= known_nxt;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_wv_r   <= wv_nxt;
      out_wp_r   <= wv_nxt ? OPW'(cur_port_r) : '0;
      out_wc_r   <= wv_nxt ? OCW'(cur_ch_r) : '0;
      out_was_r  <= was_r;
      out_pend_r <= row_ok ? OPDW'(cnt_nxt) : '0;
      out_any_r  <= (total_nxt != '0);
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_winner_valid  = out_wv_r;
  assign out_winner_port   = out_wp_r;
  assign out_winner_ch     = out_wc_r;
  assign out_was_requested = out_was_r;
  assign out_row_pending   = out_pend_r;
  assign out_any_pending   = out_any_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held for more than one cycle");

  a_locked_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_wv_r) |-> ((out_pend_r != '0) && out_any_r))
    else $error("winner reported on a row with no pending request");

  a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (bits_w_r != '0))
    else $error("round-robin search started on an empty row");

endmodule
